/* rtl/indexed_min_heap_queue_unit_macros.svh */
// Assertion macros used by the heap queue top module.
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define IMHQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define IMHQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/imhq_pkg.sv */
// Package with widths, codes and entry type of the heap queue.
package imhq_pkg;
	localparam int CAPACITY = 1024;
	localparam int NUM_VERTICES = 1024;
	localparam int KEY_W = 63;
	localparam int VID_W = 10;
	localparam int SLOT_W = 11;
	localparam int CNT_W = 11;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_DECREASE = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FULL = 3'd2,
		ST_ABSENT = 3'd3,
		ST_PRESENT = 3'd4
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VID_W-1:0] vid;
	} entry_t;

	// Map port of the vertex store.
	typedef struct packed {
		logic rd_en;
		logic [VID_W-1:0] rd_vid;
		logic wr_en;
		logic [VID_W-1:0] wr_vid;
		logic [SLOT_W-1:0] wr_slot;
		logic wr_pres;
	} vmap_req_t;
endpackage

/* rtl/imhq_heap_ram.sv */
// Heap slot memory: one write port, two registered read ports.
module imhq_heap_ram
	import imhq_pkg::*;
(
	input  logic               clk,
	input  logic               rd_a_en,
	input  logic [SLOT_W-2:0]  rd_a_addr,
	output entry_t             rd_a_data,
	input  logic               rd_b_en,
	input  logic [SLOT_W-2:0]  rd_b_addr,
	output entry_t             rd_b_data,
	input  logic               wr_en,
	input  logic [SLOT_W-2:0]  wr_addr,
	input  entry_t             wr_data
);
	entry_t mem [CAPACITY];

	// Write one slot, read two slots.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_a_en) begin
			rd_a_data <= mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_data <= mem[rd_b_addr];
		end
	end
endmodule

/* rtl/imhq_vertex_map.sv */
// Vertex map: slot and presence bit of each vertex in one memory.
module imhq_vertex_map
	import imhq_pkg::*;
(
	input  logic              clk,
	input  vmap_req_t         req,
	output logic [SLOT_W-1:0] rd_slot,
	output logic              rd_pres
);
	logic [SLOT_W:0] slot_mem [NUM_VERTICES];

	// Write and read presence and slot together.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			slot_mem[req.wr_vid] <= {req.wr_pres, req.wr_slot};
		end
		if (req.rd_en) begin
			{rd_pres, rd_slot} <= slot_mem[req.rd_vid];
		end
	end
endmodule

/* rtl/indexed_min_heap_queue_unit.sv */
// Top level of the indexed min-heap queue: sequencer over heap and map memories.
//
// channel  | signals                                          | handshake
// command  | opcode, vertex_id, key_value                     | start & !busy
// result   | out_vertex, out_key, status, entry_count         | done, one cycle
//
// Each level of sift-up or sift-down is a registered heap read, then a compare
// and write back. After reset a clearing pass marks every vertex absent; busy
// stays high through it. busy is high from acceptance until the done cycle.
// The receiver cannot stall; done lasts one cycle and busy falls with it.
`include "indexed_min_heap_queue_unit_macros.svh"
module indexed_min_heap_queue_unit
	import imhq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        opcode,
	input  logic [VID_W-1:0]  vertex_id,
	input  logic [KEY_W-1:0]  key_value,
	output logic              done,
	output logic [VID_W-1:0]  out_vertex,
	output logic [KEY_W-1:0]  out_key,
	output logic [2:0]        status,
	output logic [CNT_W-1:0]  entry_count
);
	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LOOK, S_DEC_RD, S_DEC_CHK, S_EXT_RD, S_EXT_WR,
		S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_FIN, S_DONE
	} state_t;

	state_t state_q;
	op_t op_q;
	logic [VID_W-1:0] vid_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] pos_q;
	entry_t mov_q;
	status_t st_q;
	logic [VID_W-1:0] clr_q;

	logic ra_en, rb_en, w_en;
	logic [SLOT_W-2:0] ra_addr, rb_addr, w_addr;
	entry_t ra_data, rb_data, w_data;
	vmap_req_t vreq;
	logic [SLOT_W-1:0] m_slot;
	logic m_pres;

	// Slot s (1-based) lives at address s-1.
	function automatic logic [SLOT_W-2:0] addr_of(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] t;
		t = s - SLOT_W'(1);
		return t[SLOT_W-2:0];
	endfunction

	imhq_heap_ram u_ram (
		.clk(clk), .rd_a_en(ra_en), .rd_a_addr(ra_addr), .rd_a_data(ra_data),
		.rd_b_en(rb_en), .rd_b_addr(rb_addr), .rd_b_data(rb_data),
		.wr_en(w_en), .wr_addr(w_addr), .wr_data(w_data)
	);

	imhq_vertex_map u_map (
		.clk(clk), .req(vreq), .rd_slot(m_slot), .rd_pres(m_pres)
	);

	logic [SLOT_W-1:0] par, lc, rc;
	logic lc_ok, rc_ok, pick_r;
	entry_t child;
	logic [SLOT_W-1:0] child_pos;
	assign par = pos_q >> 1;
	assign lc = {pos_q[SLOT_W-2:0], 1'b0};
	assign rc = {pos_q[SLOT_W-2:0], 1'b1};
	assign lc_ok = (pos_q[SLOT_W-1] == 1'b0) && (lc <= cnt_q);
	assign rc_ok = (pos_q[SLOT_W-1] == 1'b0) && (rc <= cnt_q);
	assign pick_r = rc_ok && (ra_data.key > rb_data.key);
	assign child = pick_r ? rb_data : ra_data;
	assign child_pos = pick_r ? rc : lc;

	// Drive memory ports from the sequencer state.
	always_comb begin
		ra_en = 1'b0; ra_addr = addr_of(pos_q);
		rb_en = 1'b0; rb_addr = addr_of(rc);
		w_en = 1'b0; w_addr = addr_of(pos_q); w_data = mov_q;
		vreq = '0;
		vreq.rd_vid = vertex_id;
		vreq.wr_vid = mov_q.vid;
		vreq.wr_slot = pos_q;
		vreq.wr_pres = 1'b1;
		unique case (state_q)
			S_CLR: begin
				vreq.wr_en = 1'b1; vreq.wr_vid = clr_q;
				vreq.wr_slot = '0; vreq.wr_pres = 1'b0;
			end
			S_IDLE: vreq.rd_en = start;
			S_DEC_RD: begin
				ra_en = 1'b1; ra_addr = addr_of(m_slot);
			end
			S_EXT_RD: begin
				ra_en = 1'b1; ra_addr = addr_of(SLOT_W'(1));
				rb_en = 1'b1; rb_addr = addr_of(cnt_q);
			end
			S_EXT_WR: begin
				vreq.wr_en = 1'b1; vreq.wr_vid = ra_data.vid; vreq.wr_pres = 1'b0;
			end
			S_UP_RD: begin
				ra_en = 1'b1; ra_addr = addr_of(par);
			end
			S_UP_CMP: begin
				if (pos_q > SLOT_W'(1) && ra_data.key > mov_q.key) begin
					w_en = 1'b1; w_data = ra_data;
					vreq.wr_en = 1'b1; vreq.wr_vid = ra_data.vid;
				end
			end
			S_DN_RD: begin
				ra_en = lc_ok; ra_addr = addr_of(lc);
				rb_en = rc_ok; rb_addr = addr_of(rc);
			end
			S_DN_CMP: begin
				if (lc_ok && !(mov_q.key < child.key)) begin
					w_en = 1'b1; w_data = child;
					vreq.wr_en = 1'b1; vreq.wr_vid = child.vid;
				end
			end
			S_FIN: begin
				w_en = 1'b1;
				vreq.wr_en = 1'b1;
			end
			default: ;
		endcase
	end

	// Clear the map after reset, then sequence one command: look up, walk the heap, write back, report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			cnt_q <= '0;
			busy <= 1'b1;
			done <= 1'b0;
			op_q <= OP_NOP;
			vid_q <= '0;
			key_q <= '0;
			pos_q <= '0;
			mov_q <= '0;
			st_q <= ST_OK;
			out_vertex <= '0;
			out_key <= '0;
			status <= '0;
			entry_count <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				// Mark every vertex absent, one map entry per cycle.
				S_CLR: begin
					clr_q <= clr_q + VID_W'(1);
					if (clr_q == '1) begin
						busy <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q <= op_t'(opcode);
						vid_q <= vertex_id;
						key_q <= key_value;
						busy <= 1'b1;
						st_q <= ST_OK;
						out_vertex <= '0;
						out_key <= '0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					unique case (op_q)
						OP_INSERT: begin
							if (m_pres) begin
								st_q <= ST_PRESENT; state_q <= S_DONE;
							end else if (cnt_q >= CNT_W'(CAPACITY)) begin
								st_q <= ST_FULL; state_q <= S_DONE;
							end else begin
								cnt_q <= cnt_q + CNT_W'(1);
								pos_q <= cnt_q + SLOT_W'(1);
								mov_q <= '{key: key_q, vid: vid_q};
								state_q <= S_UP_RD;
							end
						end
						OP_EXTRACT: begin
							if (cnt_q == '0) begin
								st_q <= ST_EMPTY; state_q <= S_DONE;
							end else begin
								state_q <= S_EXT_RD;
							end
						end
						OP_DECREASE: begin
							if (!m_pres || m_slot == '0 || m_slot > cnt_q) begin
								st_q <= ST_ABSENT; state_q <= S_DONE;
							end else begin
								state_q <= S_DEC_RD;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_DEC_RD: begin
					pos_q <= m_slot;
					state_q <= S_DEC_CHK;
				end
				S_DEC_CHK: begin
					if (key_q >= ra_data.key) begin
						st_q <= ST_ABSENT; state_q <= S_DONE;
					end else begin
						mov_q <= '{key: key_q, vid: vid_q};
						state_q <= S_UP_RD;
					end
				end
				S_EXT_RD: state_q <= S_EXT_WR;
				S_EXT_WR: begin
					out_vertex <= ra_data.vid;
					out_key <= ra_data.key;
					mov_q <= rb_data;
					cnt_q <= cnt_q - CNT_W'(1);
					pos_q <= SLOT_W'(1);
					state_q <= (cnt_q == CNT_W'(1)) ? S_DONE : S_DN_RD;
				end
				S_UP_RD: state_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (pos_q > SLOT_W'(1) && ra_data.key > mov_q.key) begin
						pos_q <= par;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DN_RD: state_q <= S_DN_CMP;
				S_DN_CMP: begin
					if (lc_ok && !(mov_q.key < child.key)) begin
						pos_q <= child_pos;
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					done <= 1'b1;
					busy <= 1'b0;
					status <= st_q;
					entry_count <= cnt_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`IMHQ_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done lasted more than a cycle")
	`IMHQ_ASSERT_IMP(a_busy_walk, clk, arst_n, state_q != S_IDLE, busy, "busy low while working")
	`IMHQ_ASSERT_IMP(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= CNT_W'(CAPACITY), "count beyond capacity")
	`IMHQ_ASSERT_IMP(a_empty_zero, clk, arst_n, done && status == ST_EMPTY, entry_count == '0,
		"empty status with entries")
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the indexed min-heap queue unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import imhq_pkg::*;

	typedef struct {
		logic [VID_W-1:0] vid;
		logic [KEY_W-1:0] key;
		status_t st;
		logic [CNT_W-1:0] cnt;
	} reply_t;

	typedef struct {
		op_t op;
		logic [VID_W-1:0] vid;
		logic [KEY_W-1:0] key;
		bit typed;
		reply_t want;
	} row_t;

	localparam logic [KEY_W-1:0] KEY_INF = '1;
	localparam int STALL_LIMIT = 4000;
	localparam reply_t NO_WANT = '{'0, '0, ST_OK, '0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] opcode = OP_NOP;
	logic [VID_W-1:0] vertex_id = '0;
	logic [KEY_W-1:0] key_value = '0;
	logic busy, done;
	logic [VID_W-1:0] out_vertex;
	logic [KEY_W-1:0] out_key;
	logic [2:0] status;
	logic [CNT_W-1:0] entry_count;

	indexed_min_heap_queue_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .vertex_id(vertex_id), .key_value(key_value),
		.done(done), .out_vertex(out_vertex), .out_key(out_key),
		.status(status), .entry_count(entry_count)
	);

	always #2 clk = ~clk;

	// Shadow heap state
	logic [KEY_W-1:0] slot_key [1:CAPACITY];
	logic [VID_W-1:0] slot_vid [1:CAPACITY];
	int slot_of [0:NUM_VERTICES-1];
	bit in_heap [0:NUM_VERTICES-1];
	int heap_size = 0;

	reply_t pending_replies [$];
	bit failed = 1'b0;
	int idle_pct = 15;
	int quiet_cycles = 0;

	// Append one expectation behind the ones already waiting
	function automatic void queue_reply(reply_t r);
		pending_replies = {pending_replies, r};
	endfunction

	function automatic void put(int s, logic [KEY_W-1:0] k, logic [VID_W-1:0] v);
		slot_key[s] = k;
		slot_vid[s] = v;
		slot_of[v] = s;
	endfunction

	function automatic void lift(int s);
		logic [KEY_W-1:0] k;
		logic [VID_W-1:0] v;
		k = slot_key[s];
		v = slot_vid[s];
		while (s > 1 && slot_key[s/2] > k) begin
			put(s, slot_key[s/2], slot_vid[s/2]);
			s = s / 2;
		end
		put(s, k, v);
	endfunction

	function automatic void sink(int s);
		logic [KEY_W-1:0] k;
		logic [VID_W-1:0] v;
		int c;
		k = slot_key[s];
		v = slot_vid[s];
		while (2 * s <= heap_size) begin
			c = 2 * s;
			if (c + 1 <= heap_size && slot_key[c] > slot_key[c+1])
				c++;
			if (k < slot_key[c])
				break;
			put(s, slot_key[c], slot_vid[c]);
			s = c;
		end
		put(s, k, v);
	endfunction

	// Apply one command to the shadow heap and return the reply it gives
	function automatic reply_t heap_apply(op_t op, logic [VID_W-1:0] vid,
			logic [KEY_W-1:0] key);
		reply_t r;
		int s;
		r.vid = '0;
		r.key = '0;
		r.st = ST_OK;
		case (op)
			OP_INSERT: begin
				if (in_heap[vid])
					r.st = ST_PRESENT;
				else if (heap_size >= CAPACITY)
					r.st = ST_FULL;
				else begin
					heap_size++;
					put(heap_size, key, vid);
					in_heap[vid] = 1'b1;
					lift(heap_size);
				end
			end
			OP_EXTRACT: begin
				if (heap_size == 0)
					r.st = ST_EMPTY;
				else begin
					r.vid = slot_vid[1];
					r.key = slot_key[1];
					put(1, slot_key[heap_size], slot_vid[heap_size]);
					heap_size--;
					in_heap[r.vid] = 1'b0;
					if (heap_size > 0)
						sink(1);
				end
			end
			OP_DECREASE: begin
				s = slot_of[vid];
				if (!in_heap[vid] || key >= slot_key[s])
					r.st = ST_ABSENT;
				else begin
					slot_key[s] = key;
					lift(s);
				end
			end
			default: ;
		endcase
		r.cnt = heap_size[CNT_W-1:0];
		return r;
	endfunction

	// Send one word and queue its reply once accepted
	task automatic send_word(op_t op, logic [VID_W-1:0] vid, logic [KEY_W-1:0] key,
			bit typed = 1'b0, reply_t want = NO_WANT);
		reply_t r;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		vertex_id <= vid;
		key_value <= key;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = heap_apply(op, vid, key);
		queue_reply(typed ? want : r);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(3))
			0: return KEY_W'($urandom_range(40));
			1: return KEY_INF;
			default: return KEY_W'({$urandom(), $urandom()});
		endcase
	endfunction

	task automatic random_word();
		logic [VID_W-1:0] v;
		logic [KEY_W-1:0] k;
		int r;
		r = $urandom_range(99);
		v = VID_W'($urandom());
		if (r < (heap_size < 30 ? 55 : 38)) begin
			send_word(OP_INSERT, v, pick_key());
		end else if (r < 70) begin
			send_word(OP_EXTRACT, v, pick_key());
		end else if (r < 95) begin
			// mostly target a vertex that is present, with a smaller key
			if (heap_size > 0 && $urandom_range(9) < 8) begin
				v = slot_vid[$urandom_range(heap_size, 1)];
				k = slot_key[slot_of[v]];
				if (k != 0 && $urandom_range(5) != 0)
					k = KEY_W'(k - 1 - ({$urandom(), $urandom()} % k));
			end else
				k = pick_key();
			send_word(OP_DECREASE, v, k);
		end else
			send_word(OP_NOP, v, pick_key());
	endtask

	// Directed rows: extremes, every operation, the empty, absent and present codes
	row_t rows [] = '{
		'{OP_EXTRACT, 10'd0, '0, 1, '{10'd0, '0, ST_EMPTY, 11'd0}},
		'{OP_NOP, 10'h3FF, KEY_INF, 1, '{10'd0, '0, ST_OK, 11'd0}},
		'{OP_DECREASE, 10'd5, 63'd3, 1, '{10'd0, '0, ST_ABSENT, 11'd0}},
		'{OP_INSERT, 10'h3FF, KEY_INF, 1, '{10'd0, '0, ST_OK, 11'd1}},
		'{OP_INSERT, 10'd0, 63'd0, 1, '{10'd0, '0, ST_OK, 11'd2}},
		'{OP_INSERT, 10'h3FF, 63'd1, 1, '{10'd0, '0, ST_PRESENT, 11'd2}},
		'{OP_DECREASE, 10'h3FF, KEY_INF, 1, '{10'd0, '0, ST_ABSENT, 11'd2}},
		'{OP_DECREASE, 10'h3FF, 63'd5, 0, NO_WANT},
		'{OP_INSERT, 10'd7, 63'd5, 0, NO_WANT},
		'{OP_INSERT, 10'h155, 63'h2AAA_AAAA_AAAA_AAAA, 0, NO_WANT},
		'{OP_INSERT, 10'h2AA, 63'h5555_5555_5555_5555, 0, NO_WANT},
		'{OP_DECREASE, 10'h2AA, 63'd0, 0, NO_WANT},
		'{OP_NOP, 10'd9, 63'd9, 0, NO_WANT},
		'{OP_EXTRACT, 10'd0, '0, 1, '{10'd0, 63'd0, ST_OK, 11'd4}},
		'{OP_EXTRACT, 10'h3FF, KEY_INF, 0, NO_WANT},
		'{OP_EXTRACT, 10'd0, '0, 0, NO_WANT},
		'{OP_EXTRACT, 10'd0, '0, 0, NO_WANT},
		'{OP_EXTRACT, 10'd0, '0, 0, NO_WANT},
		'{OP_EXTRACT, 10'd0, '0, 1, '{10'd0, 63'd0, ST_EMPTY, 11'd0}}
	};

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		reply_t w;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result vertex=%0d key=%0h status=%0d count=%0d",
					$time, out_vertex, out_key, status, entry_count);
				failed = 1'b1;
			end else begin
				w = pending_replies.pop_front();
				if (out_vertex !== w.vid) begin
					$display("%0t: out_vertex expected %0d actual %0d", $time, w.vid, out_vertex);
					failed = 1'b1;
				end
				if (out_key !== w.key) begin
					$display("%0t: out_key expected %0h actual %0h", $time, w.key, out_key);
					failed = 1'b1;
				end
				if (status !== w.st) begin
					$display("%0t: status expected %0d actual %0d", $time, w.st, status);
					failed = 1'b1;
				end
				if (entry_count !== w.cnt) begin
					$display("%0t: entry_count expected %0d actual %0d", $time, w.cnt,
						entry_count);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NUM_VERTICES; i++) begin
			in_heap[i] = 1'b0;
			slot_of[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_word(rows[i].op, rows[i].vid, rows[i].key, rows[i].typed, rows[i].want);

		// Random mix, sender idling light then heavy then none
		for (int i = 0; i < 600; i++) begin
			idle_pct = (i < 200) ? 15 : (i < 400) ? 68 : 0;
			random_word();
		end

		// Drain the heap, then hit the empty case once more
		idle_pct = 5;
		while (heap_size > 0)
			send_word(OP_EXTRACT, '0, '0);
		send_word(OP_EXTRACT, '0, '0);
		start <= 1'b0;

		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (!failed)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl
rtl/imhq_pkg.sv
rtl/imhq_heap_ram.sv
rtl/imhq_vertex_map.sv
rtl/indexed_min_heap_queue_unit.sv
tb/testbench.sv
